// File: rtl/kdeds_pkg.sv
// package for the keypad digit entry and display scan block
// holds the key map, item codes and field widths; no dependencies
`default_nettype none

package kdeds_pkg;

  localparam int DIGIT_W  = 4;
  localparam int SEL_W    = 3;
  localparam int PORT_W   = 7;
  localparam int NUMBER_W = 27;
  localparam int MS_W     = 16;
  localparam int COL_W    = 2;
  localparam int ROWS_W   = 4;

  localparam logic OPC_TICK = 1'b0;
  localparam logic OPC_KEY  = 1'b1;

  localparam logic [MS_W-1:0] ELAPSED_MAX   = 16'hFFFF;
  localparam logic [MS_W-1:0] DEBOUNCE_RST  = 16'd200;

  typedef logic [DIGIT_W-1:0] digit_t;

  // key map, indexed by row then column
  localparam digit_t KEY_MAP [4][4] = '{
    '{4'd1, 4'd2, 4'd3, 4'd0},
    '{4'd4, 4'd5, 4'd6, 4'd0},
    '{4'd7, 4'd8, 4'd9, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd0}
  };

  typedef struct packed {
    digit_t                current_key;
    logic                  key_accepted;
    logic [NUMBER_W-1:0]   entered_number;
    digit_t                digit_value;
    logic [SEL_W-1:0]      digit_select;
    logic [PORT_W-1:0]     port_word;
  } result_t;

  // lowest sensed row wins; no row keeps the held key
  function automatic digit_t decode_key(input logic [ROWS_W-1:0] rows,
                                        input logic [COL_W-1:0] col,
                                        input digit_t held);
    digit_t k;
    k = held;
    for (int r = ROWS_W - 1; r >= 0; r--) begin
      if (rows[r]) begin
        k = KEY_MAP[r][col];
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// File: rtl/kdeds_cell.sv
// one digit cell of the entry register and display scan ring
// holds a digit and a scan token; uses kdeds_pkg
`default_nettype none

module kdeds_cell #(
  parameter bit FIRST = 1'b0
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      shift_en,
  input  wire                      tick_en,
  input  wire kdeds_pkg::digit_t   digit_in,
  output kdeds_pkg::digit_t        digit_out,
  input  wire                      token_in,
  output logic                     token_out,
  input  wire kdeds_pkg::digit_t   tap_in,
  output kdeds_pkg::digit_t        tap_out
);
  import kdeds_pkg::*;

  digit_t digit;
  logic   token;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit <= '0;
      token <= FIRST;
    end else begin
      if (shift_en) begin
        digit <= digit_in;
      end
      if (tick_en) begin
        token <= token_in;
      end
    end
  end

  assign digit_out = digit;
  assign token_out = token;
  // or-chain picks the digit under the scan token
  assign tap_out   = tap_in | (token ? digit : '0);

endmodule

`default_nettype wire

// File: rtl/keypad_digit_entry_display_scan.sv
// top level of the keypad digit entry and multiplexed display scan
// uses kdeds_pkg and a chain of kdeds_cell digit cells
`default_nettype none

// Takes one item per cycle on the slave stream (a millisecond tick or a key
// event) and returns exactly one result per item on the master stream, in the
// cycle after acceptance; a result register sits between the two sides, so
// items flow back to back at one per cycle while the sink keeps up. Digits
// live in a row of cells that shift on an accepted key and pass a scan token
// on each tick; the binary entry value is kept alongside and updated with
// one constant multiply-add per key.
module keypad_digit_entry_display_scan #(
  parameter int NUM_DIGITS = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         debounce_we,
  input  wire  [15:0] debounce_wdata,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // column[1:0], row_sense[5:2], zero pad
  input  wire         s_tuser,   // opcode
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata    // port_word, digit_select, digit_value,
                                 // entered_number, key_accepted, current_key, pad
);
  import kdeds_pkg::*;

  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam longint TOP_WEIGHT = pow10(NUM_DIGITS - 1);
  localparam int     FULL_W     = $clog2(pow10(NUM_DIGITS));
  localparam int     VW         = (FULL_W > NUMBER_W) ? FULL_W : NUMBER_W;
  localparam int     PW         = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(NUM_DIGITS - 1);

  logic [MS_W-1:0]  debounce_ms;
  logic [MS_W-1:0]  elapsed;
  logic [MS_W-1:0]  elapsed_next;
  digit_t           held_key;
  digit_t           held_key_next;
  logic [PW-1:0]    scan_pos;
  logic [VW-1:0]    value;
  logic [VW-1:0]    value_next;
  logic             in_xact;
  logic             is_tick;
  logic             key_ok;
  logic [COL_W-1:0] column;
  logic [ROWS_W-1:0] row_sense;
  digit_t           shown;
  logic [SEL_W-1:0] sel;
  logic [3:0]       pos_ext;
  result_t          result;
  result_t          out_res;

  digit_t digit_chain [NUM_DIGITS+1];
  digit_t tap_chain   [NUM_DIGITS+1];
  logic   token_chain [NUM_DIGITS+1];
  logic [NUM_DIGITS-1:0] token_vec;

  assign column    = s_tdata[1:0];
  assign row_sense = s_tdata[5:2];
  assign in_xact   = s_tvalid && s_tready;
  assign is_tick   = (s_tuser == OPC_TICK);
  assign key_ok    = (s_tuser == OPC_KEY) && (elapsed > debounce_ms);
  assign s_tready  = !m_tvalid || m_tready;

  assign held_key_next = decode_key(row_sense, column, held_key);

  assign digit_chain[0]           = held_key_next;
  assign tap_chain[0]             = '0;
  assign token_chain[0]           = token_chain[NUM_DIGITS];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    kdeds_cell #(.FIRST(i == 0)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift_en  (in_xact && key_ok),
      .tick_en   (in_xact && is_tick),
      .digit_in  (digit_chain[i]),
      .digit_out (digit_chain[i+1]),
      .token_in  (token_chain[i]),
      .token_out (token_chain[i+1]),
      .tap_in    (tap_chain[i]),
      .tap_out   (tap_chain[i+1])
    );
    assign token_vec[i] = token_chain[i+1];
  end

  assign shown   = tap_chain[NUM_DIGITS];
  assign pos_ext = 4'(scan_pos);
  assign sel     = 3'd7 - pos_ext[2:0];

  // drop the top digit, then times ten plus the new key
  always_comb begin
    value_next = value;
    if (key_ok) begin
      value_next = VW'((value - VW'(digit_chain[NUM_DIGITS]) * VW'(TOP_WEIGHT)) * VW'(10)
                       + VW'(held_key_next));
    end
  end

  always_comb begin
    elapsed_next = elapsed;
    if (is_tick) begin
      if (elapsed != ELAPSED_MAX) begin
        elapsed_next = elapsed + 16'd1;
      end
    end else if (key_ok) begin
      elapsed_next = '0;
    end
  end

  always_comb begin
    result                = '0;
    result.entered_number = value_next[NUMBER_W-1:0];
    result.key_accepted   = key_ok;
    result.current_key    = key_ok ? held_key_next : held_key;
    if (is_tick) begin
      result.digit_select = sel;
      result.digit_value  = shown;
      result.port_word    = {sel, shown};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RST;
      elapsed     <= '0;
      held_key    <= '0;
      scan_pos    <= '0;
      value       <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (debounce_we) begin
        debounce_ms <= debounce_wdata;
      end
      if (in_xact) begin
        elapsed <= elapsed_next;
        value   <= value_next;
        if (key_ok) begin
          held_key <= held_key_next;
        end
        if (is_tick) begin
          scan_pos <= (scan_pos == LAST_POS) ? '0 : scan_pos + PW'(1);
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xact) begin
      out_res <= result;
    end
  end

  assign m_tdata = {2'b00, out_res};

  a_token_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(token_vec))
    else $error("scan token lost or duplicated");

  a_token_pos: assert property (@(posedge clk) disable iff (rst)
    token_vec[scan_pos])
    else $error("scan token disagrees with scan position");

  a_key_clears: assert property (@(posedge clk) disable iff (rst)
    in_xact && key_ok |=> elapsed == '0)
    else $error("accepted key did not clear elapsed count");

  a_key_no_drive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.key_accepted |-> out_res.port_word == '0)
    else $error("key result drives the display port");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// testbench for keypad_digit_entry_display_scan: directed plan, a saturation run, then random phases
// checks every result against an in-bench predictor or a typed expected result; needs kdeds_pkg and the rtl top
`timescale 1ns / 100ps

module testbench;
  import kdeds_pkg::*;

  localparam int DIGITS      = 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 80;
  localparam int SAT_TICKS   = 65540;

  typedef enum logic {PLAN_ITEM, PLAN_CFG} plan_kind_t;

  typedef struct {
    plan_kind_t  kind;
    logic        op;
    logic [1:0]  col;
    logic [3:0]  rows;
    logic [15:0] cfg;
    bit          typed;
    result_t     want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        debounce_we;
  logic [15:0] debounce_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // column[1:0], row_sense[5:2], zero pad
  logic        s_tuser;   // opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // port_word, digit_select, digit_value,
                          // entered_number, key_accepted, current_key, pad

  keypad_digit_entry_display_scan #(.NUM_DIGITS(DIGITS)) dut (
    .clk            (clk),
    .rst            (rst),
    .debounce_we    (debounce_we),
    .debounce_wdata (debounce_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata)
  );

  // predictor state
  logic [3:0]  entry_digits [DIGITS];
  int          scan_pos;
  logic [15:0] elapsed;
  logic [3:0]  held;
  logic [15:0] debounce;

  result_t     display_entry_q [$];
  plan_row_t   directed_plan [$];

  int  mismatches;
  int  checked;
  int  items_sent;
  int  keys_taken;
  int  cfg_writes;
  int  cycle_count;
  bit  idle_on;
  bit  long_hold_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               display_entry_q.size());
      $display("FAIL keypad_digit_entry_display_scan");
      $finish;
    end
  end

  function automatic logic [3:0] key_at(int r, logic [1:0] c);
    if (r == 3 || c == 2'd3) begin
      return 4'd0;
    end
    return 4'(r * 3 + int'(c) + 1);
  endfunction

  function automatic result_t scan_entry_predict(logic op, logic [1:0] col, logic [3:0] rows);
    result_t     r;
    logic [31:0] num;
    bit          found;
    r = '0;
    found = 1'b0;
    if (op == OPC_TICK) begin
      r.digit_value  = entry_digits[scan_pos];
      r.digit_select = 3'(7 - scan_pos);
      r.port_word    = {r.digit_select, r.digit_value};
      scan_pos = (scan_pos + 1) % DIGITS;
      if (elapsed != ELAPSED_MAX) begin
        elapsed = elapsed + 16'd1;
      end
    end else if (elapsed > debounce) begin
      // lowest sensed row wins, no row keeps the held key
      for (int i = 0; i < 4; i++) begin
        if (rows[i] && !found) begin
          held = key_at(i, col);
          found = 1'b1;
        end
      end
      for (int i = DIGITS - 1; i > 0; i--) begin
        entry_digits[i] = entry_digits[i-1];
      end
      entry_digits[0] = held;
      elapsed = '0;
      r.key_accepted = 1'b1;
    end
    num = 0;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      num = num * 10 + entry_digits[i];
    end
    r.entered_number = num[26:0];
    r.current_key    = held;
    return r;
  endfunction

  function automatic result_t mk_res(int port, int sel, int val, int num, int acc, int key);
    result_t r;
    r.port_word      = 7'(port);
    r.digit_select   = 3'(sel);
    r.digit_value    = 4'(val);
    r.entered_number = 27'(num);
    r.key_accepted   = 1'(acc);
    r.current_key    = 4'(key);
    return r;
  endfunction

  function automatic void add_row(plan_kind_t kind, logic op, logic [1:0] col,
                                  logic [3:0] rows, logic [15:0] cfg, bit typed,
                                  result_t want);
    plan_row_t p;
    p.kind  = kind;
    p.op    = op;
    p.col   = col;
    p.rows  = rows;
    p.cfg   = cfg;
    p.typed = typed;
    p.want  = want;
    directed_plan.push_back(p);
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at result %0d, %s: got %0d, want %0d", checked, field, got, want);
    mismatches++;
  endtask

  task automatic send_item(logic op, logic [1:0] col, logic [3:0] rows, bit typed,
                           result_t typed_res);
    int      gap;
    result_t r;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, rows, col};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = scan_entry_predict(op, col, rows);
    display_entry_q.push_back(typed ? typed_res : r);
    items_sent++;
    if (r.key_accepted) begin
      keys_taken++;
    end
  endtask

  task automatic send_random_tick();
    send_item(OPC_TICK, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 1'b0, '0);
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (display_entry_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_debounce(logic [15:0] v);
    settle();
    @(negedge clk);
    debounce_we    <= 1'b1;
    debounce_wdata <= v;
    @(negedge clk);
    debounce_we    <= 1'b0;
    debounce = v;
    cfg_writes++;
  endtask

  // mostly tick runs ending in a key near the debounce edge, the rest noise
  task automatic random_phase(logic [15:0] d, int n, bit pause_midway);
    int sent;
    int k;
    bit paused;
    sent = 0;
    paused = 1'b0;
    write_debounce(d);
    while (sent < n) begin
      if ($urandom_range(0, 9) < 7) begin
        k = int'(d) + $urandom_range(0, 3) - 1;
        if (k < 0) begin
          k = 0;
        end
        repeat (k) send_random_tick();
        send_item(OPC_KEY, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 1'b0, '0);
        sent += k + 1;
      end else begin
        send_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                  4'($urandom_range(0, 15)), 1'b0, '0);
        sent++;
      end
      if (pause_midway && !paused && sent >= n / 2) begin
        settle();
        paused = 1'b1;
      end
    end
  endtask

  // result side: random hold-offs, one long one on request
  initial begin : result_sink
    int      gap;
    result_t got;
    result_t want;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (long_hold_req) begin
        gap = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      for (int i = 0; i < gap; i++) begin
        @(negedge clk);
        m_tready <= 1'b0;
        @(posedge clk);
        if (m_tvalid && m_tready) begin
          report_mismatch("transaction while not ready", 1, 0);
        end
      end
      @(negedge clk);
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = result_t'(m_tdata[45:0]);
      if (display_entry_q.size() == 0) begin
        report_mismatch("result with none pending", m_tdata, 0);
      end else begin
        want = display_entry_q.pop_front();
        if (got.port_word != want.port_word)
          report_mismatch("port_word", got.port_word, want.port_word);
        if (got.digit_select != want.digit_select)
          report_mismatch("digit_select", got.digit_select, want.digit_select);
        if (got.digit_value != want.digit_value)
          report_mismatch("digit_value", got.digit_value, want.digit_value);
        if (got.entered_number != want.entered_number)
          report_mismatch("entered_number", got.entered_number, want.entered_number);
        if (got.key_accepted != want.key_accepted)
          report_mismatch("key_accepted", got.key_accepted, want.key_accepted);
        if (got.current_key != want.current_key)
          report_mismatch("current_key", got.current_key, want.current_key);
        if (m_tdata[47:46] != 2'b00)
          report_mismatch("pad bits", m_tdata[47:46], 0);
      end
      checked++;
    end
  end

  initial begin : stimulus
    int        wait_cycles;
    plan_row_t p;
    clk            = 1'b0;
    rst            = 1'b1;
    debounce_we    = 1'b0;
    debounce_wdata = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = OPC_TICK;
    m_tready       = 1'b0;
    mismatches     = 0;
    checked        = 0;
    items_sent     = 0;
    keys_taken     = 0;
    cfg_writes     = 0;
    cycle_count    = 0;
    idle_on        = 1'b1;
    long_hold_req  = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      entry_digits[i] = '0;
    end
    scan_pos = 0;
    elapsed  = '0;
    held     = '0;
    debounce = DEBOUNCE_RST;

    // after reset: units digit shown, key too early for the default debounce
    add_row(PLAN_ITEM, OPC_TICK, 2'd0, 4'b0000, 16'd0, 1'b1, mk_res(112, 7, 0, 0, 0, 0));
    add_row(PLAN_ITEM, OPC_KEY,  2'd0, 4'b0001, 16'd0, 1'b1, mk_res(0, 0, 0, 0, 0, 0));
    add_row(PLAN_CFG,  OPC_TICK, 2'd0, 4'b0000, 16'd0, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_KEY,  2'd0, 4'b0001, 16'd0, 1'b1, mk_res(0, 0, 0, 1, 1, 1));
    // back-to-back key: elapsed is zero, not above the limit
    add_row(PLAN_ITEM, OPC_KEY,  2'd1, 4'b0001, 16'd0, 1'b1, mk_res(0, 0, 0, 1, 0, 1));
    add_row(PLAN_ITEM, OPC_TICK, 2'd3, 4'b1111, 16'd0, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_KEY,  2'd1, 4'b0110, 16'd0, 1'b0, '0);  // several rows
    add_row(PLAN_ITEM, OPC_TICK, 2'd0, 4'b0000, 16'd0, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_KEY,  2'd0, 4'b0000, 16'd0, 1'b0, '0);  // no row: held key again
    add_row(PLAN_ITEM, OPC_TICK, 2'd2, 4'b0101, 16'd0, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_KEY,  2'd2, 4'b0100, 16'd0, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_TICK, 2'd1, 4'b1010, 16'd0, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_KEY,  2'd2, 4'b1000, 16'd0, 1'b0, '0);  // bottom row
    add_row(PLAN_ITEM, OPC_TICK, 2'd0, 4'b0000, 16'd0, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_KEY,  2'd3, 4'b0001, 16'd0, 1'b0, '0);  // last column
    add_row(PLAN_ITEM, OPC_TICK, 2'd0, 4'b0000, 16'd0, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_KEY,  2'd2, 4'b1111, 16'd0, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_TICK, 2'd0, 4'b0000, 16'd0, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_KEY,  2'd2, 4'b0010, 16'd0, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_TICK, 2'd0, 4'b0000, 16'd0, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_KEY,  2'd0, 4'b0100, 16'd0, 1'b0, '0);  // oldest digit drops
    add_row(PLAN_ITEM, OPC_TICK, 2'd0, 4'b0000, 16'd0, 1'b0, '0);  // scan has wrapped by this tick
    add_row(PLAN_ITEM, OPC_TICK, 2'd0, 4'b0000, 16'd0, 1'b0, '0);
    add_row(PLAN_CFG,  OPC_TICK, 2'd0, 4'b0000, 16'hFFFF, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_TICK, 2'd0, 4'b0000, 16'd0, 1'b0, '0);
    add_row(PLAN_ITEM, OPC_KEY,  2'd1, 4'b0001, 16'd0, 1'b0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      p = directed_plan[i];
      if (p.kind == PLAN_CFG) begin
        write_debounce(p.cfg);
      end else begin
        send_item(p.op, p.col, p.rows, p.typed, p.want);
      end
    end

    // saturate the elapsed counter at full rate; no key gets past the top limit
    idle_on = 1'b0;
    repeat (SAT_TICKS) send_random_tick();
    send_item(OPC_KEY, 2'd1, 4'b0010, 1'b0, '0);
    write_debounce(16'hFFFE);
    send_item(OPC_KEY, 2'd1, 4'b0010, 1'b0, '0);
    idle_on = 1'b1;

    random_phase(16'd0, 80, 1'b0);
    long_hold_req = 1'b1;
    random_phase(16'd1, 80, 1'b0);
    random_phase(16'd3, 70, 1'b1);
    random_phase(16'($urandom_range(0, 9)), 80, 1'b0);
    idle_on = 1'b0;
    random_phase(16'd2, 60, 1'b0);
    idle_on = 1'b1;

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (display_entry_q.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    if (display_entry_q.size() != 0) begin
      report_mismatch("results never delivered", display_entry_q.size(), 0);
    end

    $display("run covered %0d items (%0d keys taken) over %0d debounce settings",
             items_sent, keys_taken, cfg_writes);
    $display("%0d results checked, %0d mismatches, %0d cycles", checked, mismatches,
             cycle_count);
    if (mismatches == 0) begin
      $display("PASS keypad_digit_entry_display_scan");
    end else begin
      $display("FAIL keypad_digit_entry_display_scan");
    end
    $finish;
  end

endmodule
